@@ rtl/magic_signature_sniffer_defines.svh @@
// assertion macros for the magic signature sniffer
`ifndef MAGIC_SIGNATURE_SNIFFER_DEFINES_SVH
`define MAGIC_SIGNATURE_SNIFFER_DEFINES_SVH

// clocked check, off while reset is asserted
`define MSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked implication check, off while reset is asserted
`define MSS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/mss_pkg.sv @@
// shared types, codes and helpers for the magic signature sniffer
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

	localparam int OP_W      = 2;
	localparam int ENT_W     = 6;
	localparam int BPOS_W    = 3;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 4;
	localparam int OFF_W     = 10;
	localparam int VERDICT_W = 2;
	localparam int POS_W     = 12;
	localparam logic [POS_W-1:0] POS_MAX = 12'hFFF;

	typedef enum logic [OP_W-1:0] {
		OP_MAGIC   = 2'd0,
		OP_LENGTH  = 2'd1,
		OP_CONTENT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_MATCH  = 2'd0,
		VERDICT_TEXT   = 2'd1,
		VERDICT_BINARY = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FIN
	} state_t;

	// control bytes that rule out plain text
	function automatic logic is_ctrl(input logic [BYTE_W-1:0] c);
		is_ctrl = (c < 8'h09) || (c > 8'h0D && c < 8'h20) || (c == 8'h7F);
	endfunction

endpackage

`default_nettype wire

@@ rtl/magic_signature_sniffer.sv @@
// top level of the magic signature sniffer: table writes, byte sweep and verdict
//
//  channel | handshake            | words
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | op, entry, byte_pos, value, magic_length,
//          |                      | sig_start, last
//  out     | out_valid / out_stall| verdict, match_entry
//
// table writes (magic byte, length and offset) are taken only in idle
// a content byte sweeps the table through one shared window compare and one
//   byte compare, one entry per cycle, set by the single read port of the
//   entry parameter ram
// reset clears entry valid bits, mismatch bits and position and sets the text flag; the
//   magic byte ram is not cleared and needs writing before use
// in_stall is high for the whole sweep; a last byte also waits in the finish
//   state while an earlier verdict word still sits unclaimed on the output
`timescale 1ns / 1ps
`default_nettype none
`include "magic_signature_sniffer_defines.svh"

module magic_signature_sniffer #(
	parameter int ENTRIES     = 64,
	parameter int MAGIC_MAX   = 8,
	parameter int TEXT_WINDOW = 512
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [mss_pkg::OP_W-1:0]     op,
	input  wire logic [mss_pkg::ENT_W-1:0]    entry,
	input  wire logic [mss_pkg::BPOS_W-1:0]   byte_pos,
	input  wire logic [mss_pkg::BYTE_W-1:0]   value,
	input  wire logic [mss_pkg::LEN_W-1:0]    magic_length,
	input  wire logic [mss_pkg::OFF_W-1:0]    sig_start,
	input  wire logic                         last,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [mss_pkg::VERDICT_W-1:0]     verdict,
	output logic [mss_pkg::ENT_W-1:0]         match_entry
);

	import mss_pkg::*;

	// index and address widths
	localparam int IDXW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW    = (MAGIC_MAX > 1) ? $clog2(MAGIC_MAX) : 1;
	localparam int MDEP  = ENTRIES * MAGIC_MAX;
	localparam int MAW   = (MDEP > 1) ? $clog2(MDEP) : 1;
	localparam int PRM_W = LEN_W + OFF_W;
	localparam int EXT_W = POS_W + 1;
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

	state_t state_q, state_d;

	// stream state
	logic [POS_W-1:0]   pos_q;
	logic               text_q;
	logic [ENTRIES-1:0] mism_q;
	logic [ENTRIES-1:0] ent_vld_q;
	logic [BYTE_W-1:0]  byte_q;
	logic               last_q;

	// sweep sequencer
	logic [IDXW-1:0] idx_q;
	logic            issue_q;
	logic            found_q;
	logic [IDXW-1:0] found_idx_q;

	// stage 1: entry parameters come back from the ram
	logic            valid_s1;
	logic            vld_s1;
	logic [IDXW-1:0] idx_s1;

	// stage 2: magic byte comes back from the ram
	logic            valid_s2;
	logic [IDXW-1:0] idx_s2;
	logic            en_s2;
	logic            win_s2;
	logic            cpl_s2;

	// output register
	logic                 out_valid_q;
	logic [VERDICT_W-1:0] verdict_q;
	logic [ENT_W-1:0]     match_q;

	logic accept, ent_ok, bpos_ok, magic_we, param_we, out_free, fin_fire;
	logic [PRM_W-1:0] prm_rdata, prm_wdata;
	logic [LEN_W-1:0] len_norm, len_s1;
	logic [OFF_W-1:0] off_s1;
	logic [EXT_W-1:0] pos_x, end_x;
	logic [POS_W-1:0] rel;
	logic             win_s1, cpl_s1;
	logic [MAW-1:0]   mag_waddr, mag_raddr;
	logic [BYTE_W-1:0] mag_rdata;
	logic             miss_s2, bit_s2;

	// table rams
	mss_ram #(.WIDTH(BYTE_W), .DEPTH(MDEP)) u_magic_ram (
		.clk   (clk),
		.we    (magic_we),
		.waddr (mag_waddr),
		.wdata (value),
		.raddr (mag_raddr),
		.rdata (mag_rdata)
	);

	mss_ram #(.WIDTH(PRM_W), .DEPTH(ENTRIES)) u_param_ram (
		.clk   (clk),
		.we    (param_we),
		.waddr (IDXW'(entry)),
		.wdata (prm_wdata),
		.raddr (idx_q),
		.rdata (prm_rdata)
	);

	// write side decode
	assign ent_ok    = {3'b000, entry} < 9'(ENTRIES);
	assign bpos_ok   = {2'b00, byte_pos} < 5'(MAGIC_MAX);
	assign len_norm  = (magic_length != '0 && {1'b0, magic_length} <= 5'(MAGIC_MAX))
		? magic_length : '0;
	assign prm_wdata = {len_norm, sig_start};
	assign mag_waddr = MAW'(entry) * MAW'(MAGIC_MAX) + MAW'(byte_pos);

	// stage 1 window check, shared by every entry of the sweep
	// an entry never written reads as disabled
	assign len_s1    = vld_s1 ? prm_rdata[PRM_W-1:OFF_W] : '0;
	assign off_s1    = vld_s1 ? prm_rdata[OFF_W-1:0] : '0;
	assign pos_x     = {1'b0, pos_q};
	assign end_x     = EXT_W'(off_s1) + EXT_W'(len_s1);
	assign win_s1    = (pos_x >= EXT_W'(off_s1)) && (pos_x < end_x);
	assign cpl_s1    = (pos_x + EXT_W'(1)) >= end_x;
	assign rel       = pos_q - POS_W'(off_s1);
	assign mag_raddr = MAW'(idx_s1) * MAW'(MAGIC_MAX) + MAW'(rel[RW-1:0]);

	// stage 2 byte compare
	assign miss_s2 = win_s2 && (mag_rdata != byte_q);
	assign bit_s2  = mism_q[idx_s2] | miss_s2;

	assign out_free = !out_valid_q || !out_stall;

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != ST_IDLE);
		accept   = in_valid && !in_stall;
		magic_we = accept && (op == OP_MAGIC) && ent_ok && bpos_ok;
		param_we = accept && (op == OP_LENGTH) && ent_ok;
		fin_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_CONTENT) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (valid_s2 && idx_s2 == LAST_IDX) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// a last byte needs a free output slot
				if (!last_q || out_free) begin
					fin_fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			text_q      <= 1'b1;
			mism_q      <= '0;
			ent_vld_q   <= '0;
			last_q      <= 1'b0;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			found_q     <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue_q;
			valid_s2 <= valid_s1;

			if (param_we) begin
				ent_vld_q[IDXW'(entry)] <= 1'b1;
			end

			// content byte starts a sweep
			if (accept && op == OP_CONTENT) begin
				last_q  <= last;
				idx_q   <= '0;
				issue_q <= 1'b1;
				found_q <= 1'b0;
				if ({1'b0, pos_q} < EXT_W'(TEXT_WINDOW) && is_ctrl(value)) begin
					text_q <= 1'b0;
				end
			end

			if (issue_q) begin
				if (idx_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IDXW'(1);
				end
			end

			// lowest complete entry with no mismatch wins
			if (valid_s2) begin
				if (miss_s2) begin
					mism_q[idx_s2] <= 1'b1;
				end
				if (en_s2 && cpl_s2 && !bit_s2 && !found_q) begin
					found_q <= 1'b1;
				end
			end

			// a new verdict word replaces the one claimed in the same cycle
			if (out_valid_q && !out_stall && !(fin_fire && last_q)) begin
				out_valid_q <= 1'b0;
			end

			if (fin_fire) begin
				if (last_q) begin
					out_valid_q <= 1'b1;
					pos_q       <= '0;
					text_q      <= 1'b1;
					mism_q      <= '0;
				end else if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && op == OP_CONTENT) begin
			byte_q <= value;
		end
		idx_s1 <= idx_q;
		vld_s1 <= ent_vld_q[idx_q];
		idx_s2 <= idx_s1;
		en_s2  <= (len_s1 != '0);
		win_s2 <= win_s1;
		cpl_s2 <= cpl_s1;
		if (valid_s2 && en_s2 && cpl_s2 && !bit_s2 && !found_q) begin
			found_idx_q <= idx_s2;
		end
		if (fin_fire && last_q) begin
			if (found_q) begin
				verdict_q <= VERDICT_MATCH;
				match_q   <= ENT_W'(found_idx_q);
			end else begin
				verdict_q <= text_q ? VERDICT_TEXT : VERDICT_BINARY;
				match_q   <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign match_entry = match_q;

	// checks
	`MSS_ASSERT_IMP(a_issue_in_sweep, issue_q, state_q == ST_SWEEP,
		"entry issue outside of a sweep")
	`MSS_ASSERT_IMP(a_fin_drained, state_q == ST_FIN, !issue_q && !valid_s1 && !valid_s2,
		"finish reached with the sweep pipe still busy")
	`MSS_ASSERT_IMP(a_found_clean, found_q, !mism_q[found_idx_q],
		"winning entry carries a mismatch")
	`MSS_ASSERT_IMP(a_entry_zero, out_valid_q && verdict_q != VERDICT_MATCH, match_q == '0,
		"entry index given without a signature match")

endmodule

`default_nettype wire

@@ rtl/mss_ram.sv @@
// generic one-write one-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
